@@ rtl/svpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constant tables for the space vector PWM duty unit.
// No dependencies.
package svpd_pkg;

  // Fixed datapath widths, sized for the full range of fields and stage counts
  localparam int unsigned VW       = 33;  // vectoring x/y
  localparam int unsigned RW       = 34;  // rotation x/y/z
  localparam int unsigned DIV_BITS = 48;  // divider dividend and quotient
  localparam int unsigned REM_W    = 15;  // divider remainder
  localparam int unsigned TW       = 52;  // signed phase times, Q30
  localparam int unsigned PRESCALE = 14;
  localparam logic [62:0] SQRT3_Q30 = 63'd1859775393;
  localparam logic [14:0] VLIMIT_RESET = 15'd12288;

  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic        [15:0] elec_angle;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
    logic        clipped;
  } out_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic        [31:0]   z;
    logic        [15:0]   elec;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0] x_phi;
    logic signed [RW-1:0] y_phi;
    logic signed [RW-1:0] z_phi;
    logic signed [RW-1:0] x_psi;
    logic signed [RW-1:0] y_psi;
    logic signed [RW-1:0] z_psi;
    logic        [2:0]    sector;
  } rot_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] num1;
    logic [DIV_BITS-1:0] quo1;
    logic [REM_W-1:0]    rem1;
    logic                neg1;
    logic [DIV_BITS-1:0] num2;
    logic [DIV_BITS-1:0] quo2;
    logic [REM_W-1:0]    rem2;
    logic                neg2;
    logic [2:0]          sector;
  } div_t;

  // Arctangent of 2^-i as a fraction of a turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    r = '0;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Sector boundaries k*2^32/6, rounded
  function automatic logic [32:0] sector_edge(input logic [2:0] k);
    logic [32:0] r;
    r = '0;
    unique case (k)
      3'd0: r = 33'd0;
      3'd1: r = 33'd715827883;
      3'd2: r = 33'd1431655765;
      3'd3: r = 33'd2147483648;
      3'd4: r = 33'd2863311531;
      3'd5: r = 33'd3579139413;
      3'd6: r = 33'd4294967296;
      default: r = '0;
    endcase
    return r;
  endfunction

  // CORDIC gain squared in Q30, truncated at each step
  function automatic logic [63:0] gain_sq(input int unsigned n);
    logic [63:0] g;
    g = 64'd1 << 30;
    for (int unsigned i = 0; i < n; i++) begin
      g = g + (g >> (2 * i));
    end
    return g;
  endfunction

endpackage

@@ rtl/svpd_vec_cell.sv @@
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation: drives y towards zero and sums the angle.
// Depends on svpd_pkg.
module svpd_vec_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  svpd_pkg::vec_t  data_i,
  output logic            valid_o,
  output svpd_pkg::vec_t  data_o
);

  logic           valid_q;
  svpd_pkg::vec_t data_q, data_d;

  // Rotate by the direction that reduces |y|
  always_comb begin
    logic signed [svpd_pkg::VW-1:0] dx, dy;
    dx = data_i.y >>> STAGE;
    dy = data_i.x >>> STAGE;
    data_d = data_i;
    if (!data_i.y[svpd_pkg::VW-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + svpd_pkg::atan_turn(5'(STAGE));
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - svpd_pkg::atan_turn(5'(STAGE));
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/svpd_rot_cell.sv @@
`timescale 1ns / 1ps
// One rotation CORDIC micro-rotation for both the phi and psi lanes.
// Depends on svpd_pkg.
module svpd_rot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  svpd_pkg::rot_t  data_i,
  output logic            valid_o,
  output svpd_pkg::rot_t  data_o
);

  logic           valid_q;
  svpd_pkg::rot_t data_q, data_d;

  // Turn each lane towards a residual angle of zero
  always_comb begin
    logic signed [svpd_pkg::RW-1:0] at;
    at = $signed({2'b00, svpd_pkg::atan_turn(5'(STAGE))});
    data_d = data_i;
    if (!data_i.z_phi[svpd_pkg::RW-1]) begin
      data_d.x_phi = data_i.x_phi - (data_i.y_phi >>> STAGE);
      data_d.y_phi = data_i.y_phi + (data_i.x_phi >>> STAGE);
      data_d.z_phi = data_i.z_phi - at;
    end else begin
      data_d.x_phi = data_i.x_phi + (data_i.y_phi >>> STAGE);
      data_d.y_phi = data_i.y_phi - (data_i.x_phi >>> STAGE);
      data_d.z_phi = data_i.z_phi + at;
    end
    if (!data_i.z_psi[svpd_pkg::RW-1]) begin
      data_d.x_psi = data_i.x_psi - (data_i.y_psi >>> STAGE);
      data_d.y_psi = data_i.y_psi + (data_i.x_psi >>> STAGE);
      data_d.z_psi = data_i.z_psi - at;
    end else begin
      data_d.x_psi = data_i.x_psi + (data_i.y_psi >>> STAGE);
      data_d.y_psi = data_i.y_psi - (data_i.x_psi >>> STAGE);
      data_d.z_psi = data_i.z_psi + at;
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/svpd_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring-division step for both active-time lanes: one quotient bit each.
// Depends on svpd_pkg.
module svpd_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [svpd_pkg::REM_W-1:0]    divisor_i,
  input  logic                          valid_i,
  input  svpd_pkg::div_t                data_i,
  output logic                          valid_o,
  output svpd_pkg::div_t                data_o
);

  logic           valid_q;
  svpd_pkg::div_t data_q, data_d;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    logic [svpd_pkg::REM_W:0] tr1, tr2;
    logic                     b1, b2;
    tr1 = {data_i.rem1, data_i.num1[svpd_pkg::DIV_BITS-1]};
    tr2 = {data_i.rem2, data_i.num2[svpd_pkg::DIV_BITS-1]};
    b1  = (tr1 >= {1'b0, divisor_i});
    b2  = (tr2 >= {1'b0, divisor_i});
    data_d      = data_i;
    data_d.num1 = data_i.num1 << 1;
    data_d.num2 = data_i.num2 << 1;
    data_d.quo1 = {data_i.quo1[svpd_pkg::DIV_BITS-2:0], b1};
    data_d.quo2 = {data_i.quo2[svpd_pkg::DIV_BITS-2:0], b2};
    data_d.rem1 = b1 ? svpd_pkg::REM_W'(tr1 - {1'b0, divisor_i})
                     : tr1[svpd_pkg::REM_W-1:0];
    data_d.rem2 = b2 ? svpd_pkg::REM_W'(tr2 - {1'b0, divisor_i})
                     : tr2[svpd_pkg::REM_W-1:0];
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/space_vector_pwm_duty_unit.sv @@
`timescale 1ns / 1ps
// Centered three-phase space vector PWM duty unit, fully pipelined.
// Registered stages in order: input, vectoring CORDIC cells, angle, rotation CORDIC cells, multiply,
// sign split, divider cells, phase sum, output. Throughput: one item per cycle while the output is not
// stalled; set by the chain of CORDIC and divider cells. Output stall freezes the whole pipeline; input
// stall follows a held, stalled result. Reset clears all valid bits and loads the full-scale limit with 12288.
module space_vector_pwm_duty_unit #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  svpd_pkg::in_t         in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output svpd_pkg::out_t        out_o,
  input  logic                  cfg_we_i,
  input  logic [14:0]           cfg_data_i
);

  localparam int unsigned N        = CORDIC_STAGES;
  localparam int unsigned SH       = 32 - ANGLE_BITS;
  localparam logic [31:0] ROUND    = 32'd1 << (SH - 1);
  localparam logic [31:0] KEEP     = ~((32'd1 << SH) - 32'd1);
  localparam logic [63:0] GAIN     = svpd_pkg::gain_sq(N);
  localparam logic [63:0] C_FULL   = {1'b0, svpd_pkg::SQRT3_Q30} * 64'd1073741824 / GAIN;
  localparam logic signed [31:0] C_Q30 = $signed(C_FULL[31:0]);
  localparam logic signed [svpd_pkg::TW-1:0] ONE_Q30 = svpd_pkg::TW'(1) <<< 30;

  logic en;
  logic [14:0] vlimit_q;
  logic [14:0] divisor;

  // Hold the whole pipeline while a finished result is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlimit_q <= svpd_pkg::VLIMIT_RESET;
    end else if (cfg_we_i) begin
      vlimit_q <= cfg_data_i;
    end
  end

  assign divisor = (vlimit_q == '0) ? 15'd1 : vlimit_q;

  // Input stage: prescale, fold left half plane, flag zero vector
  logic           vec_v [0:N];
  svpd_pkg::vec_t vec_d [0:N];
  logic           s0_v_q;
  svpd_pkg::vec_t s0_q, s0_d;

  always_comb begin
    logic signed [svpd_pkg::VW-1:0] xe, ye;
    xe = $signed({{(svpd_pkg::VW-16){in_i.volt_d[15]}}, in_i.volt_d}) <<< svpd_pkg::PRESCALE;
    ye = $signed({{(svpd_pkg::VW-16){in_i.volt_q[15]}}, in_i.volt_q}) <<< svpd_pkg::PRESCALE;
    s0_d.elec = in_i.elec_angle;
    s0_d.zero = (in_i.volt_d == '0) && (in_i.volt_q == '0);
    if (xe[svpd_pkg::VW-1]) begin
      s0_d.x = -xe;
      s0_d.y = -ye;
      s0_d.z = 32'h80000000;
    end else begin
      s0_d.x = xe;
      s0_d.y = ye;
      s0_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  assign vec_v[0] = s0_v_q;
  assign vec_d[0] = s0_q;

  // Vectoring CORDIC chain
  for (genvar i = 0; i < N; i++) begin : g_vec
    svpd_vec_cell #(.STAGE(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vec_v[i]),
      .data_i  (vec_d[i]),
      .valid_o (vec_v[i+1]),
      .data_o  (vec_d[i+1])
    );
  end

  // Angle stage: add electrical angle, round, find sector and residual angles
  logic           rot_v [0:N];
  svpd_pkg::rot_t rot_d [0:N];
  logic           th_v_q;
  svpd_pkg::rot_t th_q, th_d;

  always_comb begin
    logic [31:0] zeff, traw, theta;
    logic [2:0]  sec;
    logic [32:0] lo, hi;
    logic [svpd_pkg::VW-1:0] mag;
    zeff  = vec_d[N].zero ? 32'd0 : vec_d[N].z;
    traw  = {vec_d[N].elec, 16'd0} + zeff;
    theta = (traw + ROUND) & KEEP;
    sec   = 3'd1
          + 3'({1'b0, theta} >= svpd_pkg::sector_edge(3'd1))
          + 3'({1'b0, theta} >= svpd_pkg::sector_edge(3'd2))
          + 3'({1'b0, theta} >= svpd_pkg::sector_edge(3'd3))
          + 3'({1'b0, theta} >= svpd_pkg::sector_edge(3'd4))
          + 3'({1'b0, theta} >= svpd_pkg::sector_edge(3'd5));
    lo  = svpd_pkg::sector_edge(sec - 3'd1);
    hi  = svpd_pkg::sector_edge(sec);
    mag = vec_d[N].zero ? {svpd_pkg::VW{1'b0}} : vec_d[N].x;
    th_d.sector = sec;
    th_d.x_phi  = $signed({1'b0, mag});
    th_d.y_phi  = '0;
    th_d.z_phi  = $signed({1'b0, 33'({1'b0, theta} - lo)});
    th_d.x_psi  = th_d.x_phi;
    th_d.y_psi  = '0;
    th_d.z_psi  = $signed({1'b0, 33'(hi - {1'b0, theta})});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_v_q <= 1'b0;
    end else if (en) begin
      th_v_q <= vec_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q <= th_d;
    end
  end

  assign rot_v[0] = th_v_q;
  assign rot_d[0] = th_q;

  // Rotation CORDIC chain for sin(phi) and sin(psi)
  for (genvar i = 0; i < N; i++) begin : g_rot
    svpd_rot_cell #(.STAGE(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rot_v[i]),
      .data_i  (rot_d[i]),
      .valid_o (rot_v[i+1]),
      .data_o  (rot_d[i+1])
    );
  end

  // Multiply by the sqrt3 / gain^2 constant
  logic signed [65:0] p1_q, p2_q;
  logic [2:0]         mul_sec_q;
  logic               mul_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= rot_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q      <= C_Q30 * rot_d[N].y_psi;
      p2_q      <= C_Q30 * rot_d[N].y_phi;
      mul_sec_q <= rot_d[N].sector;
    end
  end

  // Split sign and magnitude, drop the prescale bits
  logic           div_v [0:svpd_pkg::DIV_BITS];
  svpd_pkg::div_t div_d [0:svpd_pkg::DIV_BITS];
  logic           abs_v_q;
  svpd_pkg::div_t abs_q, abs_d;

  always_comb begin
    logic [65:0] a1, a2;
    a1 = p1_q[65] ? 66'(-p1_q) : p1_q;
    a2 = p2_q[65] ? 66'(-p2_q) : p2_q;
    abs_d.num1   = a1[svpd_pkg::PRESCALE +: svpd_pkg::DIV_BITS];
    abs_d.num2   = a2[svpd_pkg::PRESCALE +: svpd_pkg::DIV_BITS];
    abs_d.neg1   = p1_q[65];
    abs_d.neg2   = p2_q[65];
    abs_d.quo1   = '0;
    abs_d.quo2   = '0;
    abs_d.rem1   = '0;
    abs_d.rem2   = '0;
    abs_d.sector = mul_sec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_v_q <= 1'b0;
    end else if (en) begin
      abs_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      abs_q <= abs_d;
    end
  end

  assign div_v[0] = abs_v_q;
  assign div_d[0] = abs_q;

  // Divider chain by the full-scale limit
  for (genvar i = 0; i < svpd_pkg::DIV_BITS; i++) begin : g_div
    svpd_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (divisor),
      .valid_i   (div_v[i]),
      .data_i    (div_d[i]),
      .valid_o   (div_v[i+1]),
      .data_o    (div_d[i+1])
    );
  end

  // Form phase times from T1, T2 and half of T0
  logic signed [svpd_pkg::TW-1:0] ta_q, tb_q, tc_q, ta_d, tb_d, tc_d;
  logic [2:0] sum_sec_q;
  logic       sum_v_q;

  always_comb begin
    logic signed [svpd_pkg::TW-1:0] q1, q2, t1, t2, h0;
    q1 = $signed({{(svpd_pkg::TW-svpd_pkg::DIV_BITS){1'b0}},
                  div_d[svpd_pkg::DIV_BITS].quo1});
    q2 = $signed({{(svpd_pkg::TW-svpd_pkg::DIV_BITS){1'b0}},
                  div_d[svpd_pkg::DIV_BITS].quo2});
    t1 = div_d[svpd_pkg::DIV_BITS].neg1 ? -q1 : q1;
    t2 = div_d[svpd_pkg::DIV_BITS].neg2 ? -q2 : q2;
    h0 = (ONE_Q30 - t1 - t2) >>> 1;
    unique case (div_d[svpd_pkg::DIV_BITS].sector)
      3'd1: begin ta_d = t1 + t2 + h0; tb_d = t2 + h0;      tc_d = h0;           end
      3'd2: begin ta_d = t1 + h0;      tb_d = t1 + t2 + h0; tc_d = h0;           end
      3'd3: begin ta_d = h0;           tb_d = t1 + t2 + h0; tc_d = t2 + h0;      end
      3'd4: begin ta_d = h0;           tb_d = t1 + h0;      tc_d = t1 + t2 + h0; end
      3'd5: begin ta_d = t2 + h0;      tb_d = h0;           tc_d = t1 + t2 + h0; end
      default: begin ta_d = t1 + t2 + h0; tb_d = h0;        tc_d = t1 + h0;      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else if (en) begin
      sum_v_q <= div_v[svpd_pkg::DIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ta_q      <= ta_d;
      tb_q      <= tb_d;
      tc_q      <= tc_d;
      sum_sec_q <= div_d[svpd_pkg::DIV_BITS].sector;
    end
  end

  // Saturation test for one phase time
  function automatic logic out_of_range(input logic signed [svpd_pkg::TW-1:0] t);
    return t[svpd_pkg::TW-1] || (t > ONE_Q30);
  endfunction

  // Clamp to 0..1 and scale to 16 bits with rounding
  function automatic logic [15:0] duty_of(input logic signed [svpd_pkg::TW-1:0] t);
    logic [30:0] dc;
    logic [46:0] sc;
    if (t[svpd_pkg::TW-1]) begin
      dc = '0;
    end else if (t > ONE_Q30) begin
      dc = 31'd1 << 30;
    end else begin
      dc = t[30:0];
    end
    sc = {dc, 16'd0} - {16'd0, dc} + (47'd1 << 29);
    return sc[45:30];
  endfunction

  // Output register
  svpd_pkg::out_t out_q, out_d;
  logic           out_v_q;

  always_comb begin
    out_d.duty_a  = duty_of(ta_q);
    out_d.duty_b  = duty_of(tb_q);
    out_d.duty_c  = duty_of(tc_q);
    out_d.sector  = sum_sec_q;
    out_d.clipped = out_of_range(ta_q) || out_of_range(tb_q) || out_of_range(tc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // A delivered result always names a real sector
  a_sector_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.sector != 3'd0) && (out_o.sector != 3'd7))
    else $error("sector out of range");

  // Input is only held back behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // A frozen pipeline keeps its divider entry and phase-sum valid bits
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(div_v[0]) && $stable(sum_v_q))
    else $error("pipeline moved while stalled");

endmodule

@@ test/space_vector_pwm_duty_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for space_vector_pwm_duty_unit: random and directed voltage vectors,
// a bit-exact duty predictor and random idling on both channels. Depends on svpd_pkg.
module space_vector_pwm_duty_unit_test;

  localparam int unsigned N_STAGES   = 16;
  localparam int unsigned DRAIN_WAIT = 2 * N_STAGES + 54 + 40;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam longint      Q30 = longint'(1) << 30;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  svpd_pkg::in_t  in_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  svpd_pkg::out_t out_o;
  logic           cfg_we_i = 1'b0;
  logic [14:0]    cfg_data_i = '0;

  svpd_pkg::in_t  vector_feed_q[$];
  svpd_pkg::out_t duty_expect_q[$];
  logic [14:0]    limit_shadow = svpd_pkg::VLIMIT_RESET;
  bit             calm = 1'b0;
  int             mismatches = 0;
  int             quiet_cycles = 0;

  space_vector_pwm_duty_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Arctangent of 2^-i in turns, and rounded sector edges
  function automatic longint arc_step(int i);
    longint tbl[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    return tbl[i];
  endfunction

  function automatic longint edge_at(int k);
    longint tbl[7] = '{64'd0, 64'd715827883, 64'd1431655765, 64'd2147483648,
                       64'd2863311531, 64'd3579139413, 64'd4294967296};
    return tbl[k];
  endfunction

  // Rotation CORDIC from (m, 0) by angle a; returns the y leg
  function automatic longint sine_leg(longint m, longint a);
    longint yy, dx, dy;
    yy = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      dx = yy >>> i;
      dy = m >>> i;
      if (a >= 0) begin
        m -= dx; yy += dy; a -= arc_step(i);
      end else begin
        m += dx; yy -= dy; a += arc_step(i);
      end
    end
    return yy;
  endfunction

  function automatic logic [15:0] phase_duty(longint t, inout bit clip);
    longint r;
    if (t < 0) begin
      clip = 1'b1; t = 0;
    end
    if (t > Q30) begin
      clip = 1'b1; t = Q30;
    end
    r = (t * 65535 + (longint'(1) << 29)) >>> 30;
    return r[15:0];
  endfunction

  function automatic svpd_pkg::out_t predict_duty(svpd_pkg::in_t it, logic [14:0] lim);
    longint x, y, dx, dy, yphi, ypsi, g, c, vl, den, t1, t2, h0, ta, tb, tc;
    logic [31:0] z, theta;
    int sec;
    bit clip;
    svpd_pkg::out_t r;
    x = longint'($signed(it.volt_d)) * 16384;
    y = longint'($signed(it.volt_q)) * 16384;
    z = '0;
    clip = 1'b0;
    // Vectoring pass gives magnitude and vector angle; zero vector counts as angle 0
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < N_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += arc_step(i);
        end else begin
          x -= dx; y += dy; z -= arc_step(i);
        end
      end
    end else begin
      x = 0;
    end
    theta = {it.elec_angle, 16'h0000} + z;
    theta = (theta + 32'h00008000) & 32'hFFFF0000;
    sec = 1;
    for (int k = 1; k < 6; k++) if (longint'(theta) >= edge_at(k)) sec++;
    yphi = sine_leg(x, longint'(theta) - edge_at(sec - 1));
    ypsi = sine_leg(x, edge_at(sec) - longint'(theta));
    g = Q30;
    for (int i = 0; i < N_STAGES; i++) g += g >>> (2 * i);
    c = (longint'(1859775393) * Q30) / g;
    vl = (lim == 0) ? 1 : longint'(lim);
    den = vl * 16384;
    t1 = (c * ypsi) / den;
    t2 = (c * yphi) / den;
    h0 = (Q30 - t1 - t2) >>> 1;
    case (sec)
      1: begin ta = t1 + t2 + h0; tb = t2 + h0;      tc = h0;           end
      2: begin ta = t1 + h0;      tb = t1 + t2 + h0; tc = h0;           end
      3: begin ta = h0;           tb = t1 + t2 + h0; tc = t2 + h0;      end
      4: begin ta = h0;           tb = t1 + h0;      tc = t1 + t2 + h0; end
      5: begin ta = t2 + h0;      tb = h0;           tc = t1 + t2 + h0; end
      default: begin ta = t1 + t2 + h0; tb = h0;     tc = t1 + h0;      end
    endcase
    r.duty_a  = phase_duty(ta, clip);
    r.duty_b  = phase_duty(tb, clip);
    r.duty_c  = phase_duty(tc, clip);
    r.sector  = sec[2:0];
    r.clipped = clip;
    return r;
  endfunction

  // Driver: hold an item until taken, then offer the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) duty_expect_q.push_back(predict_duty(in_i, limit_shadow));
      if (!in_valid_i || !in_stall_o) begin
        if (vector_feed_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          in_i       <= vector_feed_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin
    svpd_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (duty_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_o);
        end else begin
          want = duty_expect_q.pop_front();
          if (want.duty_a !== out_o.duty_a || want.duty_b !== out_o.duty_b ||
              want.duty_c !== out_o.duty_c || want.sector !== out_o.sector ||
              want.clipped !== out_o.clipped) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_o);
          end
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 28);
    end
  end

  // Watchdog on cycles with no item taken on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_vector(int q, int d, int ang);
    svpd_pkg::in_t it;
    it.volt_q     = q[15:0];
    it.volt_d     = d[15:0];
    it.elec_angle = ang[15:0];
    vector_feed_q.push_back(it);
  endtask

  // Wait for the pipeline to empty, then let any late work settle
  task automatic drain();
    while (vector_feed_q.size() != 0 || in_valid_i || duty_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [14:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    limit_shadow = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_batch(int count);
    int kind, span;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      span = (limit_shadow < 2048) ? 2048 : int'(limit_shadow);
      if (kind == 0)
        add_vector(0, 0, $urandom_range(65535));
      else if (kind < 5)
        add_vector($urandom_range(span) - span / 2, $urandom_range(span) - span / 2,
                   $urandom_range(65535));
      else
        add_vector($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    end
  endtask

  initial begin
    logic [14:0] limits[6] = '{15'd1024, 15'd32767, 15'd0, 15'd5000, 15'd12288, 15'd20000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero vector, field extremes, sector edges, overmodulation at reset limit
    add_vector(0, 0, 0);
    add_vector(0, 0, 21845);
    add_vector(0, 0, 65535);
    add_vector(-32768, -32768, 0);
    add_vector(32767, 32767, 65535);
    add_vector(-32768, 32767, 32768);
    add_vector(32767, -32768, 12345);
    add_vector(0, 4096, 0);
    add_vector(0, 4096, 10923);
    add_vector(0, 4096, 21845);
    add_vector(0, 4096, 32768);
    add_vector(0, 4096, 43691);
    add_vector(0, 4096, 54613);
    add_vector(4096, 0, 0);
    add_vector(-4096, 0, 0);
    add_vector(0, -4096, 0);
    add_vector(1, 0, 0);
    add_vector(0, -1, 0);
    add_vector(12000, 12000, 5000);
    add_vector(-1, -1, 65535);
    drain();

    // Phases over the limit range; one phase runs with no idling at all
    foreach (limits[p]) begin
      set_limit(limits[p]);
      calm = (p == 3);
      random_batch(290);
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
